FILE: src/mandelbrot_escape_pixel_colorer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel colourer
// Each macro expands to a clocked concurrent assertion on clk, disabled
// while rst_n is low. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_PIXEL_COLORER_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_COLORER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MEP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mep check failed");
`define MEP_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mep forbidden condition seen");
`else
`define MEP_ASSERT(lbl, prop)
`define MEP_NEVER(lbl, expr)
`endif
`endif

FILE: src/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Shared widths, register indexes, reset values, command and status types
// for the escape-time pixel colourer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mep_pkg;

  // Fixed point format of c and z
  localparam int COORD_BITS           = 32;
  localparam int FRAC_BITS            = 28;
  localparam int PIXEL_INDEX_BITS_DEF = 12;

  // Square or cross product after the fraction shift, and iteration sum width
  localparam int PROD_W = 2 * COORD_BITS - FRAC_BITS;
  localparam int IT_SW  = PROD_W + 2;

  localparam int ITER_W     = 16;
  localparam int COUNT_W    = ITER_W + 1;
  localparam int HUE_W      = 8;
  localparam int COLOUR_W   = 8;
  localparam int DIVIDEND_W = ITER_W + HUE_W;
  localparam int DIVISOR_W  = ITER_W + HUE_W - 1;
  localparam int DIV_CNT_W  = $clog2(HUE_W);
  localparam int RAMP_W     = 10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

  // Reset values
  localparam logic signed [COORD_BITS-1:0] X_MIN_RST    = -32'sd644245094;
  localparam logic        [COORD_BITS-2:0] X_STEP_RST   = 31'd571226;
  localparam logic signed [COORD_BITS-1:0] Y_MIN_RST    = -32'sd256691862;
  localparam logic        [COORD_BITS-2:0] Y_STEP_RST   = 31'd571697;
  localparam logic        [ITER_W-1:0]     MAX_ITER_RST = 16'd100;

  // Hue wheel constants
  localparam logic [HUE_W-1:0]    HUE_SIXTH      = 8'd60;
  localparam logic [HUE_W-1:0]    HUE_THIRD      = 8'd120;
  localparam logic [HUE_W-1:0]    HUE_HALF       = 8'd180;
  localparam logic [HUE_W-1:0]    HUE_TWO_THIRDS = 8'd240;
  localparam logic [RAMP_W-1:0]   RAMP_GAIN      = 10'd17;
  localparam logic [COLOUR_W-1:0] COLOUR_FULL    = 8'hFF;
  localparam logic [COLOUR_W-1:0] COLOUR_NONE    = 8'h00;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_min;
    logic        [COORD_BITS-2:0] x_step;
    logic signed [COORD_BITS-1:0] y_min;
    logic        [COORD_BITS-2:0] y_step;
    logic        [ITER_W-1:0]     max_iter;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic map_mul;
    logic map_add;
    logic it_mul;
    logic it_add;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic iter_last;
    logic escaped;
    logic div_last;
    logic out_free;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SEED,
    ST_MUL,
    ST_ADD,
    ST_DIVLD,
    ST_DIV,
    ST_COLOUR
  } state_t;

endpackage

FILE: src/mep_ctrl.sv
// ----------------------------------------------------------------------------
// mep_ctrl
// Sequencer for one pixel: map, iterate, divide for hue, colour, hand off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_colorer_defines.svh"

module mep_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mep_pkg::sts_t sts_i,
  output mep_pkg::cmd_t cmd_o
);
  import mep_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd_o.map_mul = 1'b1;
        state_nxt     = ST_SEED;
      end
      ST_SEED: begin
        cmd_o.map_add = 1'b1;
        state_nxt     = sts_i.limit_zero ? ST_COLOUR : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.it_mul = 1'b1;
        state_nxt    = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.it_add = 1'b1;
        if (sts_i.iter_last) begin
          state_nxt = ST_COLOUR;
        end else if (sts_i.escaped) begin
          state_nxt = ST_DIVLD;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DIVLD: begin
        cmd_o.div_load = 1'b1;
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_nxt = ST_COLOUR;
        end
      end
      ST_COLOUR: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `MEP_ASSERT(a_cmd_exclusive, ($onehot0(cmd_o)))
  `MEP_ASSERT(a_capture_maps, (cmd_o.capture |=> state_r == ST_MAP))
  `MEP_ASSERT(a_last_iter_colours,
              ((state_r == ST_ADD) && sts_i.iter_last |=> state_r == ST_COLOUR))

endmodule

FILE: src/mep_dpath.sv
// ----------------------------------------------------------------------------
// mep_dpath
// Coordinate mapping, z*z + c iteration, hue division and colour lookup,
// with the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_colorer_defines.svh"

module mep_dpath #(
  parameter int PIXEL_INDEX_BITS = mep_pkg::PIXEL_INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mep_pkg::cfg_t                 cfg_i,
  input  mep_pkg::cmd_t                 cmd_i,
  output mep_pkg::sts_t                 sts_o,
  input  logic [PIXEL_INDEX_BITS-1:0]   in_column,
  input  logic [PIXEL_INDEX_BITS-1:0]   in_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mep_pkg::COUNT_W-1:0]   out_iter_count,
  output logic                          out_inside_res,
  output logic [mep_pkg::COLOUR_W-1:0]  out_red,
  output logic [mep_pkg::COLOUR_W-1:0]  out_green,
  output logic [mep_pkg::COLOUR_W-1:0]  out_blue
);
  import mep_pkg::*;

  localparam int MAP_PW  = COORD_BITS - 1 + PIXEL_INDEX_BITS;
  localparam int MAP_SW  = MAP_PW + 2;
  localparam int PRODF_W = 2 * COORD_BITS;

  localparam logic signed [MAP_SW-1:0] MAP_HI =
    {{(MAP_SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [MAP_SW-1:0] MAP_LO =
    {{(MAP_SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [IT_SW-1:0] IT_HI =
    {{(IT_SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [IT_SW-1:0] IT_LO =
    {{(IT_SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [IT_SW-1:0] FOUR =
    {{(IT_SW-FRAC_BITS-3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

  function automatic logic signed [COORD_BITS-1:0] clamp_map(
    input logic signed [MAP_SW-1:0] v
  );
    logic signed [MAP_SW-1:0] s;
    s = v;
    if (v > MAP_HI) s = MAP_HI;
    if (v < MAP_LO) s = MAP_LO;
    return s[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_it(
    input logic signed [IT_SW-1:0] v
  );
    logic signed [IT_SW-1:0] s;
    s = v;
    if (v > IT_HI) s = IT_HI;
    if (v < IT_LO) s = IT_LO;
    return s[COORD_BITS-1:0];
  endfunction

  logic [PIXEL_INDEX_BITS-1:0] col_r, row_r;
  logic [MAP_PW-1:0]           map_px_r, map_py_r, map_px_nxt, map_py_nxt;
  logic signed [COORD_BITS-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [COORD_BITS-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [PROD_W-1:0]     xx_r, yy_r, xy_r, xx_nxt, yy_nxt, xy_nxt;
  logic signed [PRODF_W-1:0]    xx_full, yy_full, xy_full;
  logic signed [MAP_SW-1:0]     map_sx, map_sy;
  logic signed [IT_SW-1:0]      xx_e, yy_e, xy_e, cx_e, cy_e, xs, ys, mag;
  logic [ITER_W-1:0]            k_r;
  logic [COUNT_W-1:0]           count_r;
  logic                         inside_r;
  logic [DIVIDEND_W-1:0]        rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]         dvs_r;
  logic [DIV_CNT_W-1:0]         step_r;
  logic [HUE_W-1:0]             q_r;
  logic                         div_ge;
  logic [HUE_W-1:0]             hue_mod, wheel_dist, ramp;
  logic [RAMP_W-1:0]            ramp_x;
  logic [COLOUR_W-1:0]          f, red_nxt, green_nxt, blue_nxt;
  logic                         out_valid_r;
  logic [COUNT_W-1:0]           out_count_r;
  logic                         out_inside_r;
  logic [COLOUR_W-1:0]          out_red_r, out_green_r, out_blue_r;

  // Map: step times index, then add base and saturate
  always_comb begin
    map_px_nxt = MAP_PW'(cfg_i.x_step) * MAP_PW'(col_r);
    map_py_nxt = MAP_PW'(cfg_i.y_step) * MAP_PW'(row_r);
    map_sx = {{(MAP_SW-COORD_BITS){cfg_i.x_min[COORD_BITS-1]}}, cfg_i.x_min};
    map_sy = {{(MAP_SW-COORD_BITS){cfg_i.y_min[COORD_BITS-1]}}, cfg_i.y_min};
    cx_nxt = clamp_map(map_sx + $signed({2'b00, map_px_r}));
    cy_nxt = clamp_map(map_sy + $signed({2'b00, map_py_r}));
  end

  // Iteration: squares and cross product, floor-shifted by the fraction
  always_comb begin
    xx_full = x_r * x_r;
    yy_full = y_r * y_r;
    xy_full = x_r * y_r;
    xx_nxt  = xx_full[PRODF_W-1:FRAC_BITS];
    yy_nxt  = yy_full[PRODF_W-1:FRAC_BITS];
    xy_nxt  = xy_full[PRODF_W-1:FRAC_BITS];
  end

  always_comb begin
    xx_e  = {{(IT_SW-PROD_W){xx_r[PROD_W-1]}}, xx_r};
    yy_e  = {{(IT_SW-PROD_W){yy_r[PROD_W-1]}}, yy_r};
    xy_e  = {{(IT_SW-PROD_W){xy_r[PROD_W-1]}}, xy_r};
    cx_e  = {{(IT_SW-COORD_BITS){cx_r[COORD_BITS-1]}}, cx_r};
    cy_e  = {{(IT_SW-COORD_BITS){cy_r[COORD_BITS-1]}}, cy_r};
    xs    = xx_e - yy_e + cx_e;
    ys    = (xy_e <<< 1) + cy_e;
    mag   = xx_e + yy_e;
    x_nxt = clamp_it(xs);
    y_nxt = clamp_it(ys);
  end

  // Restoring division, one quotient bit a step
  always_comb begin
    div_ge  = rem_r >= {1'b0, dvs_r};
    rem_nxt = div_ge ? rem_r - {1'b0, dvs_r} : rem_r;
  end

  // Hue to RGB
  always_comb begin
    if (q_r < HUE_THIRD) begin
      hue_mod = q_r;
    end else if (q_r < HUE_TWO_THIRDS) begin
      hue_mod = q_r - HUE_THIRD;
    end else begin
      hue_mod = q_r - HUE_TWO_THIRDS;
    end
    wheel_dist = (hue_mod >= HUE_SIXTH) ? hue_mod - HUE_SIXTH : HUE_SIXTH - hue_mod;
    ramp   = HUE_SIXTH - wheel_dist;
    ramp_x = RAMP_W'(ramp) * RAMP_GAIN;
    f      = ramp_x[RAMP_W-1:2];
    red_nxt   = COLOUR_NONE;
    green_nxt = COLOUR_NONE;
    blue_nxt  = COLOUR_NONE;
    if (!inside_r) begin
      if (q_r < HUE_SIXTH) begin
        red_nxt   = COLOUR_FULL;
        green_nxt = f;
      end else if (q_r < HUE_THIRD) begin
        red_nxt   = f;
        green_nxt = COLOUR_FULL;
      end else if (q_r < HUE_HALF) begin
        green_nxt = COLOUR_FULL;
        blue_nxt  = f;
      end else if (q_r < HUE_TWO_THIRDS) begin
        green_nxt = f;
        blue_nxt  = COLOUR_FULL;
      end else begin
        red_nxt  = f;
        blue_nxt = COLOUR_FULL;
      end
    end
  end

  always_comb begin
    sts_o.limit_zero = (cfg_i.max_iter == '0);
    sts_o.iter_last  = (({1'b0, k_r} + COUNT_W'(1)) == {1'b0, cfg_i.max_iter});
    sts_o.escaped    = (mag > FOUR);
    sts_o.div_last   = (step_r == '0);
    sts_o.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      col_r <= in_column;
      row_r <= in_row;
    end
    if (cmd_i.map_mul) begin
      map_px_r <= map_px_nxt;
      map_py_r <= map_py_nxt;
    end
    if (cmd_i.map_add) begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      x_r      <= '0;
      y_r      <= '0;
      k_r      <= '0;
      count_r  <= {1'b0, cfg_i.max_iter} + COUNT_W'(1);
      inside_r <= 1'b1;
    end
    if (cmd_i.it_mul) begin
      xx_r <= xx_nxt;
      yy_r <= yy_nxt;
      xy_r <= xy_nxt;
    end
    if (cmd_i.it_add) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      k_r <= k_r + 1'b1;
      // escape seen before the next iteration: count is iterations done + 1
      if (!sts_o.iter_last && sts_o.escaped) begin
        count_r  <= COUNT_W'(k_r) + COUNT_W'(2);
        inside_r <= 1'b0;
      end
    end
    if (cmd_i.div_load) begin
      // 255 * count as (count << 8) - count
      rem_r  <= {count_r[ITER_W-1:0], {HUE_W{1'b0}}}
              - DIVIDEND_W'(count_r[ITER_W-1:0]);
      dvs_r  <= {cfg_i.max_iter, {(HUE_W-1){1'b0}}};
      step_r <= DIV_CNT_W'(HUE_W - 1);
      q_r    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_r  <= rem_nxt;
      dvs_r  <= dvs_r >> 1;
      step_r <= step_r - 1'b1;
      q_r    <= {q_r[HUE_W-2:0], div_ge};
    end
    if (cmd_i.out_load) begin
      out_count_r  <= count_r;
      out_inside_r <= inside_r;
      out_red_r    <= red_nxt;
      out_green_r  <= green_nxt;
      out_blue_r   <= blue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_iter_count = out_count_r;
  assign out_inside_res = out_inside_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;

  `MEP_ASSERT(a_inside_count,
              (cmd_i.out_load && inside_r |->
               count_r == ({1'b0, cfg_i.max_iter} + COUNT_W'(1))))
  `MEP_ASSERT(a_escape_count_range,
              (cmd_i.out_load && !inside_r |->
               (count_r <= {1'b0, cfg_i.max_iter}) && (count_r >= COUNT_W'(2))))
  `MEP_NEVER(a_no_div_inside, (cmd_i.div_load && inside_r))

endmodule

FILE: src/mandelbrot_escape_pixel_colorer.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_colorer
// Escape-time colouring of one pixel of the Mandelbrot set per item.
//
// Give a pixel column and row on the input channel; the block maps them to
// c = (x_min + column*x_step, y_min + row*y_step) in signed Q3.28, iterates
// z = z*z + c from zero up to max_iter times on one shared set of three
// 32x32 multipliers, and returns the escape count, an interior flag and an
// RGB colour. The escape test |z|^2 > 4 uses the squares of the previous
// iteration, so escape after k iterations gives count k+1 and a point that
// never escapes gives max_iter+1 and black. Escaped pixels take hue
// floor(255*count/max_iter) at full saturation and value, found by a
// one-bit-per-cycle divider. An item passes through capture, mapping
// (multiply, then add base and saturate), the iteration loop (multiply,
// then add and saturate, for each iteration), the hue division when the
// point escapes (load, then one quotient bit per step) and colouring,
// where it waits for a free output register. The iteration loop sets the
// rate. One item is worked on at a time; a new item is accepted as soon
// as the previous one has reached the output register, even while that
// result waits to be taken. Write configuration only while no item is in
// progress; max_iter of zero gives count 1, interior, black.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_colorer #(
  parameter int PIXEL_INDEX_BITS = mep_pkg::PIXEL_INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel items in
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PIXEL_INDEX_BITS-1:0]     in_column,
  input  logic [PIXEL_INDEX_BITS-1:0]     in_row,
  // coloured items out
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mep_pkg::COUNT_W-1:0]     out_iter_count,
  output logic                            out_inside_res,
  output logic [mep_pkg::COLOUR_W-1:0]    out_red,
  output logic [mep_pkg::COLOUR_W-1:0]    out_green,
  output logic [mep_pkg::COLOUR_W-1:0]    out_blue,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mep_pkg::COORD_BITS-1:0]  cfg_data
);
  import mep_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // Register writes are always accepted
  assign cfg_ready = 1'b1;

  // Register bank; drop writes to indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min    <= X_MIN_RST;
      cfg_r.x_step   <= X_STEP_RST;
      cfg_r.y_min    <= Y_MIN_RST;
      cfg_r.y_step   <= Y_STEP_RST;
      cfg_r.max_iter <= MAX_ITER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_MIN:    cfg_r.x_min    <= cfg_data;
        CFG_X_STEP:   cfg_r.x_step   <= cfg_data[COORD_BITS-2:0];
        CFG_Y_MIN:    cfg_r.y_min    <= cfg_data;
        CFG_Y_STEP:   cfg_r.y_step   <= cfg_data[COORD_BITS-2:0];
        CFG_MAX_ITER: cfg_r.max_iter <= cfg_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: one pixel at a time through map, iterate, divide, colour
  mep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // Arithmetic and the output register
  mep_dpath #(
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg_r),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_column      (in_column),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_iter_count (out_iter_count),
    .out_inside_res (out_inside_res),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

endmodule
